// File: hw/rtl/ssmt_pkg.sv
package ssmt_pkg;

  localparam int MAX_IDS_DEF = 1024;

  localparam int CMD_W     = 3;
  localparam int ID_W      = 10;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 11;
  localparam int LIM_W     = 17;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  typedef struct packed {
    logic accept;
    logic rd1;
    logic exec;
    logic load_out;
  } ssmt_ctl_t;

  typedef struct packed {
    logic out_free;
  } ssmt_sts_t;

endpackage

// File: hw/rtl/ssmt_ctrl.sv
module ssmt_ctrl
  import ssmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ssmt_sts_t sts,
  output ssmt_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD1  = 4'b0010,
    S_RD2  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE) || ((state_r == S_OUT) && sts.out_free);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    ctl.accept   = accept;
    ctl.rd1      = (state_r == S_RD1);
    ctl.exec     = (state_r == S_RD2);
    ctl.load_out = (state_r == S_OUT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_RD1;
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) state_nxt = accept ? S_RD1 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/ssmt_dp.sv
module ssmt_dp
  import ssmt_pkg::*;
#(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssmt_ctl_t            ctl,
  output ssmt_sts_t            sts,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ID_W-1:0]      in_ident,
  input  logic [VAL_W-1:0]     in_value,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_present,
  output logic [VAL_W-1:0]     out_value,
  output logic [CNT_OUT_W-1:0] out_count
);

  localparam int SLOT_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_IDS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);

  logic [SLOT_W-1:0] slot_mem [MAX_IDS];
  logic [ID_W-1:0]   id_mem   [MAX_IDS];
  logic [VAL_W-1:0]  val_mem  [MAX_IDS];

  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [VAL_W-1:0]  val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] slot_rd_r;
  logic [ID_W-1:0]   id_rd_r;
  logic [VAL_W-1:0]  val_rd_r;
  logic [ID_W-1:0]   last_r;
  logic              res_present_r;
  logic [VAL_W-1:0]  res_value_r;
  logic              out_valid_r;
  logic              out_present_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic [SLOT_W+ID_W-1:0]     in_ext, id_ext, last_ext;
  logic [SLOT_W-1:0]          in_idx, id_idx, last_idx, tail_idx;
  logic [CNT_W-1:0]           count_dec;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;
  logic [SLOT_W-1:0]          id_raddr;
  logic                       id_ok, last_ok, member;
  logic                       res_present;
  logic [VAL_W-1:0]           res_value;

  logic              slot_we, id_we, val_we;
  logic [SLOT_W-1:0] slot_wa, slot_wd, id_wa;
  logic [ID_W-1:0]   id_wd;

  assign in_ext   = {{SLOT_W{1'b0}}, in_ident};
  assign id_ext   = {{SLOT_W{1'b0}}, id_r};
  assign last_ext = {{SLOT_W{1'b0}}, last_r};
  assign in_idx   = in_ext[SLOT_W-1:0];
  assign id_idx   = id_ext[SLOT_W-1:0];
  assign last_idx = last_ext[SLOT_W-1:0];

  assign count_dec = count_r - CNT_W'(1);
  assign tail_idx  = count_dec[SLOT_W-1:0];
  assign id_raddr  = ctl.accept ? tail_idx : slot_rd_r;

  assign id_ok   = {{(LIM_W-ID_W){1'b0}}, id_r} < MAX_LIM;
  assign last_ok = {{(LIM_W-ID_W){1'b0}}, last_r} < MAX_LIM;
  assign member  = id_ok && ({1'b0, slot_rd_r} < count_r) && (id_rd_r == id_r);

  always_comb begin
    count_nxt   = count_r;
    slot_we     = 1'b0;
    slot_wa     = id_idx;
    slot_wd     = count_r[SLOT_W-1:0];
    id_we       = 1'b0;
    id_wa       = count_r[SLOT_W-1:0];
    id_wd       = id_r;
    val_we      = 1'b0;
    res_present = 1'b0;
    res_value   = '0;
    case (cmd_r)
      CMD_INSERT: begin
        if (id_ok) begin
          val_we = 1'b1;
          if (!member && (count_r < MAX_CNT)) begin
            id_we     = 1'b1;
            slot_we   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (member) begin
          count_nxt = count_dec;
          if (count_dec != '0) begin
            id_we   = 1'b1;
            id_wa   = slot_rd_r;
            id_wd   = last_r;
            slot_we = last_ok;
            slot_wa = last_idx;
            slot_wd = slot_rd_r;
          end
        end
      end
      CMD_CLEAR: count_nxt = '0;
      CMD_QUERY: begin
        if (member) begin
          res_present = 1'b1;
          res_value   = val_rd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      slot_rd_r <= slot_mem[in_idx];
      val_rd_r  <= val_mem[in_idx];
    end
    if (ctl.accept || ctl.rd1) begin
      id_rd_r <= id_mem[id_raddr];
    end
    if (ctl.exec && slot_we) slot_mem[slot_wa] <= slot_wd;
    if (ctl.exec && id_we)   id_mem[id_wa]     <= id_wd;
    if (ctl.exec && val_we)  val_mem[id_idx]   <= val_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= in_cmd;
      id_r  <= in_ident;
      val_r <= in_value;
    end
    if (ctl.rd1) last_r <= id_rd_r;
    if (ctl.exec) begin
      res_present_r <= res_present;
      res_value_r   <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  assign count_ext = {{CNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_present_r <= res_present_r;
      out_value_r   <= res_value_r;
      out_count_r   <= count_ext[CNT_OUT_W-1:0];
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_present  = out_present_r;
  assign out_value    = out_value_r;
  assign out_count    = out_count_r;

endmodule

// File: hw/rtl/sparse_set_membership_table.sv
// An accepted item runs through states RD1, RD2 and OUT; its result item is
// registered once the output is free. A new item can be taken in OUT, after
// two dependent reads of the slot and id memories and the write-back cycle.
// Reset: synchronous active-low rst_n clears the member count and control;
// memory contents stay as they are, no clearing pass.
module sparse_set_membership_table
  import ssmt_pkg::*;
#(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] cmd, [12:3] ident, [44:13] value_in, [47:45] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] present, [32:1] value_out, [43:33] member_count, [47:44] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ssmt_ctl_t            ctl;
  ssmt_sts_t            sts;
  logic                 out_present;
  logic [VAL_W-1:0]     out_value;
  logic [CNT_OUT_W-1:0] out_count;

  ssmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ssmt_dp #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_cmd      (in_tdata[CMD_W-1:0]),
    .in_ident    (in_tdata[CMD_W+ID_W-1:CMD_W]),
    .in_value    (in_tdata[CMD_W+ID_W+VAL_W-1:CMD_W+ID_W]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_present (out_present),
    .out_value   (out_value),
    .out_count   (out_count)
  );

  assign out_tdata = {{(OUT_TDATA_W-1-VAL_W-CNT_OUT_W){1'b0}}, out_count, out_value, out_present};

endmodule
